@@ rtl/sktbs_pkg.sv @@
// ----------------------------------------------------------------------------
// sktbs_pkg
// Shared types and constants of the sorted key table search block.
// ----------------------------------------------------------------------------
`default_nettype none

package sktbs_pkg;

  // Field widths fixed by the item layout
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned REF_W      = 64;
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned KLEN_W     = 4;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned KBYTES_W   = 4;
  localparam int unsigned S_TDATA_W  = 144;
  localparam int unsigned M_TDATA_W  = 80;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES   = 2'd1;

  // Request kinds carried in tuser
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic wr_rec;   // store one record
    logic start;    // load search operands, issue first probe read
    logic step;     // consume probe data, advance bounds
    logic publish;  // move result into the output register
  } sktbs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cnt_zero; // effective record count is zero
    logic hit;      // probed key prefix equals search key
    logic more;     // another probe remains in the chosen half
    logic out_free; // output register can take a result this cycle
  } sktbs_sts_t;

  // Mask that keeps the leading nbytes bytes of a 64-bit key
  function automatic logic [KEY_W-1:0] prefix_mask(logic [KLEN_W-1:0] nbytes);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (KLEN_W'(b) < nbytes) begin
        m[KEY_W-1-8*b -: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sktbs_ram.sv @@
// ----------------------------------------------------------------------------
// sktbs_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sktbs_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/sktbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// sktbs_ctrl
// Sequencer: accepts requests, steps the binary search, hands off results.
// ----------------------------------------------------------------------------
`default_nettype none

module sktbs_ctrl
  import sktbs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       req_valid_i,
  input  wire logic       req_func_i,
  output      logic       req_ready_o,
  input  wire sktbs_sts_t sts_i,
  output      sktbs_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_PROBE  = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i & req_ready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_func_i == FUNC_SEARCH) begin
            cmd_o.start = 1'b1;
            state_d     = sts_i.cnt_zero ? ST_FINISH : ST_PROBE;
          end else begin
            cmd_o.wr_rec = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        cmd_o.step = 1'b1;
        if (sts_i.hit || !sts_i.more) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hold the result until the output register frees up
        if (sts_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sktbs_dp.sv @@
// ----------------------------------------------------------------------------
// sktbs_dp
// Datapath: configuration registers, record RAMs, search bounds, key
// compare and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sktbs_dp
  import sktbs_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned KEY_BYTES   = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration writes
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // request fields
  input  wire logic [SLOT_W-1:0]     slot_i,
  input  wire logic [REF_W-1:0]      entry_reference_i,
  input  wire logic [KEY_W-1:0]      key_i,
  input  wire logic [KLEN_W-1:0]     key_length_i,
  // control
  input  wire sktbs_cmd_t            cmd_i,
  output      sktbs_sts_t            sts_o,
  // result
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic                  found_o,
  output      logic [REF_W-1:0]      reference_o,
  output      logic [POS_W-1:0]      position_o
);

  localparam int unsigned AW   = $clog2(MAX_ENTRIES);
  localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned KW   = 8 * KEY_BYTES;
  localparam int unsigned NCW  = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int unsigned SCW  = (CW > SLOT_W) ? CW : SLOT_W;

  // Configuration registers
  logic [COUNT_W-1:0]  entry_count_q;
  logic [KBYTES_W-1:0] key_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      key_bytes_q   <= KBYTES_W'(KEY_BYTES);
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_ENTRY_COUNT) begin
        entry_count_q <= cfg_data_i;
      end else if (cfg_index_i == REG_KEY_BYTES) begin
        key_bytes_q <= cfg_data_i[KBYTES_W-1:0];
      end
    end
  end

  // Saturate count, stored key bytes and key length
  logic [CW-1:0]     count;
  logic [KLEN_W-1:0] kb_sat, klen_sat, len;

  assign count    = (NCW'(entry_count_q) > NCW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
                                                              : CW'(entry_count_q);
  assign kb_sat   = (key_bytes_q > KBYTES_W'(KEY_BYTES)) ? KLEN_W'(KEY_BYTES)
                                                         : key_bytes_q;
  assign klen_sat = (key_length_i > KLEN_W'(KEY_BYTES)) ? KLEN_W'(KEY_BYTES)
                                                        : key_length_i;
  assign len      = (klen_sat < kb_sat) ? klen_sat : kb_sat;

  // Search registers
  logic [CW-1:0]    lo_q, hi_q;
  logic [AW-1:0]    mid_q;
  logic [KEY_W-1:0] key_q, mask_q;
  logic             found_q;
  logic [REF_W-1:0] ref_q;
  logic [POS_W-1:0] pos_q;

  // Candidate next probes for both halves, from registers only
  logic [CW-1:0] mid_ext, nlo, mid_r, mid_l;
  logic          right_ok, left_ok;

  assign mid_ext  = CW'(mid_q);
  assign nlo      = mid_ext + CW'(1);
  assign mid_r    = ((hi_q - nlo) >> 1) + nlo;
  assign mid_l    = ((mid_ext - lo_q) >> 1) + lo_q;
  assign right_ok = nlo < hi_q;
  assign left_ok  = lo_q < mid_ext;

  // Record RAMs
  logic [KW-1:0]    rd_key;
  logic [REF_W-1:0] rd_ref;
  logic [AW-1:0]    raddr, waddr;
  logic             wr_en;

  assign waddr = AW'(slot_i);
  assign wr_en = cmd_i.wr_rec & (SCW'(slot_i) < SCW'(MAX_ENTRIES));

  sktbs_ram #(
    .WIDTH (KW),
    .DEPTH (MAX_ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (key_i[KEY_W-1 -: KW]),
    .raddr_i (raddr),
    .rdata_o (rd_key)
  );

  sktbs_ram #(
    .WIDTH (REF_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (entry_reference_i),
    .raddr_i (raddr),
    .rdata_o (rd_ref)
  );

  // Prefix compare of the probed key against the masked search key
  logic [KEY_W-1:0] stored;
  logic             cmp_eq, cmp_lt, more;
  logic [AW-1:0]    next_mid;

  assign stored   = (KEY_W'(rd_key) << (KEY_W - KW)) & mask_q;
  assign cmp_eq   = (stored == key_q);
  assign cmp_lt   = (stored < key_q);
  assign more     = cmp_lt ? right_ok : left_ok;
  assign next_mid = cmp_lt ? AW'(mid_r) : AW'(mid_l);

  // Read address: first probe at start, then the chosen half's midpoint
  always_comb begin
    priority if (cmd_i.start) begin
      raddr = AW'(count >> 1);
    end else if (cmd_i.step) begin
      raddr = next_mid;
    end else begin
      raddr = mid_q;
    end
  end

  // Load operands and advance bounds
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      lo_q    <= '0;
      hi_q    <= count;
      mid_q   <= AW'(count >> 1);
      key_q   <= key_i & prefix_mask(len);
      mask_q  <= prefix_mask(len);
      found_q <= 1'b0;
      ref_q   <= '0;
    end else if (cmd_i.step) begin
      mid_q   <= next_mid;
      found_q <= cmp_eq;
      ref_q   <= cmp_eq ? rd_ref : '0;
      if (cmp_lt) begin
        lo_q <= nlo;
      end else begin
        hi_q <= mid_ext;
      end
    end
  end

  // Last probed position survives searches with no probe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (cmd_i.step) begin
      pos_q <= POS_W'(mid_q);
    end
  end

  // Output register
  logic             out_valid_q;
  logic             out_found_q;
  logic [REF_W-1:0] out_ref_q;
  logic [POS_W-1:0] out_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_found_q <= found_q;
      out_ref_q   <= ref_q;
      out_pos_q   <= pos_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = out_found_q;
  assign reference_o = out_ref_q;
  assign position_o  = out_pos_q;

  // Status back to the sequencer
  assign sts_o.cnt_zero = (count == '0);
  assign sts_o.hit      = cmp_eq;
  assign sts_o.more     = more;
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

endmodule

`default_nettype wire

@@ rtl/sorted_key_table_binary_search.sv @@
// Sorted key table with binary search. A write request stores one record
// (key and 64-bit reference) in the cycle it is accepted; a search request
// probes the first entry_count records, one probe per cycle, each probe being
// one read of the record RAMs and one masked key compare. The accept cycle
// loads the operands and issues the first probe read, the probe state then
// steps through the probes, and the finish state hands the result to the
// output register. That register lets the next request in while the result
// waits; the hand-off itself stalls for as long as an earlier result still
// sits unaccepted in the output register. Records must be written before
// they are searched; the RAMs are not cleared at reset.
// ----------------------------------------------------------------------------
// sorted_key_table_binary_search
// Top level: stream ports, configuration port, sequencer and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_binary_search
  import sktbs_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned KEY_BYTES   = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write channel
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // request stream
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  // slot[9:0], entry_reference[73:10], key[137:74], key_length[141:138]
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
  // func[0]
  input  wire logic                  s_axis_tuser,
  // result stream
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // reference[63:0], position[73:64]
  output      logic [M_TDATA_W-1:0]  m_axis_tdata,
  // found[0]
  output      logic                  m_axis_tuser
);

  sktbs_cmd_t       cmd;
  sktbs_sts_t       sts;
  logic [REF_W-1:0] reference;
  logic [POS_W-1:0] position;

  // Configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  sktbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_func_i  (s_axis_tuser),
    .req_ready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sktbs_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BYTES   (KEY_BYTES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_valid_i & cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .slot_i            (s_axis_tdata[9:0]),
    .entry_reference_i (s_axis_tdata[73:10]),
    .key_i             (s_axis_tdata[137:74]),
    .key_length_i      (s_axis_tdata[141:138]),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .found_o           (m_axis_tuser),
    .reference_o       (reference),
    .position_o        (position)
  );

  // Pack the result, zero fill to whole bytes
  assign m_axis_tdata = {(M_TDATA_W - REF_W - POS_W)'(0), position, reference};

endmodule

`default_nettype wire

@@ rtl/sktbs_chk.sv @@
// ----------------------------------------------------------------------------
// sktbs_chk
// Port-level checks of the sorted key table search block.
// ----------------------------------------------------------------------------
`default_nettype none

module sktbs_chk
  import sktbs_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic                 s_axis_tuser,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata,
  input wire logic                 m_axis_tuser
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A miss carries a zero reference
  a_miss_ref: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[REF_W-1:0] == '0)
    else $error("nonzero reference on a miss");

  // A search keeps the request side closed for the next cycle
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_SEARCH |=> !s_axis_tready)
    else $error("request taken during a search");

  // A record write leaves the request side open
  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_WRITE |=> s_axis_tready)
    else $error("record write stalled the request side");

  // Padding bits of the result stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:REF_W+POS_W] == '0)
    else $error("result padding not zero");

endmodule

bind sorted_key_table_binary_search sktbs_chk u_sktbs_chk (.*);

`default_nettype wire
